FILE: src/bdil3_pkg.sv
// Shared types, sizes and helpers for the 3x3 binary dilation block.
package bdil3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int KMASK_W   = 9;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROWIDX_W = $clog2(MAX_HEIGHT);
    localparam int INROW_W  = $clog2(MAX_HEIGHT + 2);

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MASK  = 2'd2;

    // Command codes of an input word.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [CFG_W-1:0]   RESET_WIDTH  = 11'd10;
    localparam logic [CFG_W-1:0]   RESET_HEIGHT = 11'd10;
    localparam logic [KMASK_W-1:0] RESET_KERNEL = 9'd186;

    typedef struct packed {
        logic cmd;
        logic pixel_in;
    } item_t;

    typedef struct packed {
        logic pixel_out;
        logic row_end;
        logic frame_end;
    } result_t;

    // One classified pixel on its way to the window stage.
    typedef struct packed {
        logic             pix;
        logic             has_out;
        logic [COL_W-1:0] col;
    } task_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [COL_W-1:0]    last_col;
        logic [ROWIDX_W-1:0] last_row;
        logic [KMASK_W-1:0]  kernel;
    } frame_cfg_t;

    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
        logic [WIDTH_W-1:0] r;
        if (v == '0)
            r = WIDTH_W'(1);
        else if (32'(v) > MAX_WIDTH)
            r = WIDTH_W'(MAX_WIDTH);
        else
            r = WIDTH_W'(v);
        return r;
    endfunction

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
        logic [HEIGHT_W-1:0] r;
        if (v == '0)
            r = HEIGHT_W'(1);
        else if (32'(v) > MAX_HEIGHT)
            r = HEIGHT_W'(MAX_HEIGHT);
        else
            r = HEIGHT_W'(v);
        return r;
    endfunction

endpackage

FILE: src/bdil3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdil3_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bdil3_front.sv
// Input side: classify each word and track the input raster position.
module bdil3_front import bdil3_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  item_t      item,
    input  frame_cfg_t cfg,
    input  logic       restart,
    output logic       task_push,
    output task_t      task_word
);

    logic [INROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]   in_col_reg, in_col_next;
    logic               idle_drain;
    logic               frame_last;
    logic               col_wrap;

    always_comb
    begin
        // drop a drain word that arrives before any pixel of the frame
        idle_drain = (item.cmd == CMD_DRAIN) && (in_row_reg == '0) && (in_col_reg == '0);
        col_wrap   = (in_col_reg == cfg.last_col);
        frame_last = (in_row_reg == INROW_W'(cfg.height) + INROW_W'(1))
                     && (in_col_reg == '0);

        task_word.pix     = (item.cmd == CMD_PIXEL) && (in_row_reg < INROW_W'(cfg.height))
                            && item.pixel_in;
        task_word.has_out = (in_row_reg >= INROW_W'(2))
                            || ((in_row_reg == INROW_W'(1)) && (in_col_reg != '0));
        task_word.col     = in_col_reg;
        task_push         = accept && !idle_drain;

        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        if (restart)
        begin
            in_row_next = '0;
            in_col_next = '0;
        end
        else if (task_push)
        begin
            if (frame_last)
            begin
                in_row_next = '0;
                in_col_next = '0;
            end
            else if (col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + INROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
        end
        else
        begin
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
        end
    end

endmodule

FILE: src/bdil3_queue.sv
// Short queue of classified pixels between the front and the window stage.
module bdil3_queue import bdil3_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr,
    input  task_t wr_word,
    input  logic  rd,
    output task_t rd_word,
    output logic  full,
    output logic  not_empty
);

    task_t             q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
            count_next = count_reg + QCNT_W'(1);
        else if (rd && !wr)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (rd)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    assign rd_word   = q_mem_reg[rd_ptr_reg];
    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);

endmodule

FILE: src/bdil3_back.sv
// Window stage: line buffers, 3x3 window, border masking and result buffer.
module bdil3_back import bdil3_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  frame_cfg_t cfg,
    input  logic       restart,
    input  logic       q_not_empty,
    input  task_t      q_word,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output result_t    result
);

    localparam logic [KMASK_W-1:0] SHIFT_KEEP = 9'h0DB;
    localparam logic [KMASK_W-1:0] TOP_ROW    = 9'h007;
    localparam logic [KMASK_W-1:0] BOTTOM_ROW = 9'h1C0;
    localparam logic [KMASK_W-1:0] LEFT_COL   = 9'h049;
    localparam logic [KMASK_W-1:0] RIGHT_COL  = 9'h124;

    // window stage
    logic                s2_valid_reg;
    task_t               s2_task_reg;
    logic                fwd_reg;
    logic [1:0]          fwd_data_reg;
    logic [1:0]          ram_rdata;
    logic [1:0]          lines;
    logic [1:0]          line_wdata;
    logic                s2_fire;
    logic [KMASK_W-1:0]  window_reg, window_next, window_shift, win_masked;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [ROWIDX_W-1:0] out_row_reg, out_row_next;
    logic                hit;
    result_t             res;

    // result buffer, two words
    result_t             ob_reg [2];
    logic                ob_wr_reg, ob_rd_reg;
    logic [1:0]          ob_count_reg;
    logic                ob_full;
    logic                ob_push;
    logic                ob_pop;

    assign ob_full = (ob_count_reg == 2'd2);
    assign s2_fire = s2_valid_reg && (!s2_task_reg.has_out || !ob_full);
    assign q_pop   = q_not_empty && (!s2_valid_reg || s2_fire);
    assign ob_push = s2_fire && s2_task_reg.has_out;
    assign ob_pop  = pop && (ob_count_reg != 2'd0);

    // bit 1 holds the line two above, bit 0 the line above
    bdil3_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (s2_fire),
        .waddr (s2_task_reg.col),
        .wdata (line_wdata),
        .re    (q_pop),
        .raddr (q_word.col),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        lines      = fwd_reg ? fwd_data_reg : ram_rdata;
        line_wdata = {lines[0], s2_task_reg.pix};

        window_shift = ((window_reg >> 1) & SHIFT_KEEP)
                     | {s2_task_reg.pix, 2'b00, lines[0], 2'b00, lines[1], 2'b00};

        win_masked = window_shift;
        if (out_row_reg == '0)
            win_masked = win_masked & ~TOP_ROW;
        if (out_row_reg == cfg.last_row)
            win_masked = win_masked & ~BOTTOM_ROW;
        if (out_col_reg == '0)
            win_masked = win_masked & ~LEFT_COL;
        if (out_col_reg == cfg.last_col)
            win_masked = win_masked & ~RIGHT_COL;

        // kernel position i looks at the reflected neighbour 8-i
        hit = 1'b0;
        for (int i = 0; i < KMASK_W; i++)
        begin
            if (cfg.kernel[i] && win_masked[KMASK_W-1-i])
                hit = 1'b1;
        end

        res.pixel_out = hit;
        res.row_end   = (out_col_reg == cfg.last_col);
        res.frame_end = res.row_end && (out_row_reg == cfg.last_row);

        window_next  = window_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart)
        begin
            window_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (s2_fire)
        begin
            window_next = window_shift;
            if (s2_task_reg.has_out)
            begin
                if (res.frame_end)
                begin
                    window_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (res.row_end)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROWIDX_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s2_task_reg  <= q_word;
            fwd_data_reg <= line_wdata;
        end
        if (ob_push)
        begin
            ob_reg[ob_wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            window_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            ob_wr_reg    <= 1'b0;
            ob_rd_reg    <= 1'b0;
            ob_count_reg <= 2'd0;
        end
        else
        begin
            if (q_pop)
            begin
                s2_valid_reg <= 1'b1;
                // same column written this cycle: take the new line data
                fwd_reg      <= s2_fire && (q_word.col == s2_task_reg.col);
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end
            window_reg  <= window_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (ob_push)
                ob_wr_reg <= ~ob_wr_reg;
            if (ob_pop)
                ob_rd_reg <= ~ob_rd_reg;
            if (ob_push && !ob_pop)
                ob_count_reg <= ob_count_reg + 2'd1;
            else if (ob_pop && !ob_push)
                ob_count_reg <= ob_count_reg - 2'd1;
        end
    end

    assign empty  = (ob_count_reg == 2'd0);
    assign result = ob_reg[ob_rd_reg];

endmodule

FILE: src/binary_dilation_3x3.sv
// Top level of the streaming 3x3 binary dilation block.
//
//   channel  direction  handshake           payload
//   item     in         push / full         item_t   {cmd, pixel_in}
//   result   out        empty / pop         result_t {pixel_out, row_end, frame_end}
//   config   in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word is accepted per clock cycle while results are popped; the figure is set by the
// single line-buffer RAM, read once when a word enters the window stage and
// written once when it leaves, with a bypass for back-to-back use of one column.
// A result passes from the queue through the window-stage register and the result
// buffer before it is on the result ports.
// Reset clears positions, window and queues; the line buffers are not cleared,
// since every entry that is read before it is written lands on a masked border.
// Full rises only when the four-word queue backs up behind a stalled result side.
module binary_dilation_3x3 import bdil3_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  item_t                item,
    output logic                 empty,
    input  logic                 pop,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [KMASK_W-1:0]  kernel_reg;
    frame_cfg_t          cfg;
    logic                cfg_wr;
    logic                restart;
    logic                accept;
    logic                task_push;
    task_t               task_word;
    logic                q_pop;
    task_t               q_word;
    logic                q_not_empty;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    // a size write abandons the frame in progress
    assign restart   = cfg_wr && ((cfg_index == REG_FRAME_WIDTH)
                                  || (cfg_index == REG_FRAME_HEIGHT));
    assign accept    = push && !full;

    always_comb
    begin
        cfg.height   = height_reg;
        cfg.last_col = COL_W'(width_reg - WIDTH_W'(1));
        cfg.last_row = ROWIDX_W'(height_reg - HEIGHT_W'(1));
        cfg.kernel   = kernel_reg;
    end

    // store sizes already clamped to the supported range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= clamp_width(RESET_WIDTH);
            height_reg <= clamp_height(RESET_HEIGHT);
            kernel_reg <= RESET_KERNEL;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= clamp_width(cfg_data);
                REG_FRAME_HEIGHT: height_reg <= clamp_height(cfg_data);
                REG_KERNEL_MASK:  kernel_reg <= cfg_data[KMASK_W-1:0];
                default:          ;
            endcase
        end
    end

    bdil3_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg       (cfg),
        .restart   (restart),
        .task_push (task_push),
        .task_word (task_word)
    );

    bdil3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (task_push),
        .wr_word   (task_word),
        .rd        (q_pop),
        .rd_word   (q_word),
        .full      (full),
        .not_empty (q_not_empty)
    );

    bdil3_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .restart     (restart),
        .q_not_empty (q_not_empty),
        .q_word      (q_word),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

endmodule
